// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: src/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants and types of the trimmed-mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;
	localparam int CHANNELS    = 4;
	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 12;
	localparam int TRIM_COUNT  = 2;

	localparam int CH_W    = 2;
	localparam int SMP_W   = 12;
	localparam int TDATA_W = 16;

	localparam int ENTRIES = CHANNELS * WINDOW;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int POS_W   = $clog2(WINDOW);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
	localparam int DIV_N   = WINDOW - TRIM_COUNT;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [SAMPLE_BITS-1:0] smp_t;
	typedef logic [SUM_W-1:0]       sum_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		smp_t  data;
	} wr_req_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;
endpackage

// File: src/tmf_store.sv
// ----------------------------------------------------------------------------
// tmf_store
// Sample memory, one write and one registered read port; unwritten entries
// read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module tmf_store (
	input  logic             clk,
	input  logic             arst_n,
	input  tmf_pkg::wr_req_t wr,
	input  tmf_pkg::rd_req_t rd,
	output tmf_pkg::smp_t    rd_data
);
	import tmf_pkg::*;

	smp_t               mem_q [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	smp_t               rd_raw_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_raw_q <= mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= vld_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;
endmodule

// File: src/tmf_scan.sv
// ----------------------------------------------------------------------------
// tmf_scan
// Walks one channel's window, one read a cycle, and accumulates sum,
// maximum and minimum; gives sum less both extremes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmf_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tmf_pkg::addr_t   base,
	output tmf_pkg::rd_req_t rd,
	input  tmf_pkg::smp_t    rd_data,
	output logic             done,
	output tmf_pkg::sum_t    trim
);
	import tmf_pkg::*;

	logic             busy_q;
	logic [POS_W-1:0] cnt_q;
	addr_t            base_q;
	logic             vld_s1;
	logic             first_s1;
	logic             last_s1;
	logic             done_q;
	smp_t             hi_q;
	smp_t             lo_q;
	sum_t             sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == POS_W'(WINDOW - 1)) begin
					busy_q <= 1'b0;
				end
			end
			vld_s1   <= busy_q;
			first_s1 <= busy_q && (cnt_q == '0);
			last_s1  <= busy_q && (cnt_q == POS_W'(WINDOW - 1));
			done_q   <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q <= base;
		end
		if (vld_s1) begin
			if (first_s1) begin
				hi_q  <= rd_data;
				lo_q  <= rd_data;
				sum_q <= SUM_W'(rd_data);
			end else begin
				if (rd_data > hi_q) begin
					hi_q <= rd_data;
				end
				if (rd_data < lo_q) begin
					lo_q <= rd_data;
				end
				sum_q <= sum_q + SUM_W'(rd_data);
			end
		end
	end

	assign rd.en   = busy_q;
	assign rd.addr = base_q + ADDR_W'(cnt_q);
	assign done    = done_q;
	assign trim    = sum_q - SUM_W'(hi_q) - SUM_W'(lo_q);

	`ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && (busy_q || vld_s1 || done_q))
	`ASSERT_PROP(a_done_after_last, clk, arst_n, done_q |-> $past(last_s1))
endmodule

// File: src/tmf_div.sv
// ----------------------------------------------------------------------------
// tmf_div
// Divide by the constant window-less-trim count: reciprocal multiply, then
// one remainder compare to correct the quotient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmf_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tmf_pkg::sum_t trim,
	output logic          done,
	output tmf_pkg::smp_t quot
);
	import tmf_pkg::*;

	localparam int              SHIFT   = SUM_W;
	localparam logic [SUM_W:0]  RECIP   = (SUM_W + 1)'((64'd1 << SHIFT) / DIV_N);
	localparam sum_t            DIVISOR = SUM_W'(DIV_N);

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	sum_t             trim_s1;
	sum_t             trim_s2;
	sum_t             trim_s3;
	logic [2*SUM_W:0] prod_c;
	logic [2*SUM_W:0] prod_s2;
	sum_t             q0_s3;
	logic [2*SUM_W-1:0] back_c;
	sum_t             rem_c;
	sum_t             q_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign prod_c = trim_s1 * RECIP;

	always_ff @(posedge clk) begin
		trim_s1 <= trim;
		prod_s2 <= prod_c;
		trim_s2 <= trim_s1;
		q0_s3   <= prod_s2[SHIFT +: SUM_W];
		trim_s3 <= trim_s2;
	end

	// q0 is the true quotient or one below it
	assign back_c = q0_s3 * DIVISOR;
	assign rem_c  = trim_s3 - back_c[SUM_W-1:0];
	assign q_c    = (rem_c >= DIVISOR) ? q0_s3 + 1'b1 : q0_s3;
	assign quot   = q_c[SAMPLE_BITS-1:0];
	assign done   = v_s3;

	`ASSERT_NEVER(a_rem_range, clk, arst_n, v_s3 && ({1'b0, rem_c} >= {DIVISOR, 1'b0}))
endmodule

// File: src/multichannel_trimmed_mean_filter.sv
// A new sample is accepted only in the idle state, so no new sample is taken until
//   the last result is loaded into the output register; the window scan runs through
//   the single sample memory read port, one entry per cycle.
// An out-of-range channel returns zero through the hold state.
// Reset (arst_n low, asynchronous): memory reads as zero, position zero,
//   no output item pending.
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_filter
// Per-channel moving window, sum less max and min, divided by WINDOW-2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multichannel_trimmed_mean_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tmf_pkg::TDATA_W-1:0] s_tdata,  // [11:0] sample
	input  logic [tmf_pkg::CH_W-1:0]    s_tuser,  // [1:0] channel
	input  logic                        s_tvalid,
	output logic                        s_tready,
	output logic [tmf_pkg::TDATA_W-1:0] m_tdata,  // [11:0] filtered
	output logic [tmf_pkg::CH_W-1:0]    m_tuser,  // [1:0] out_channel
	output logic                        m_tvalid,
	input  logic                        m_tready
);
	import tmf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]      state_q;
	logic [POS_W-1:0] pos_q;
	logic [CH_W-1:0] ch_q;
	smp_t            res_q;
	logic            m_valid_q;
	logic [CH_W-1:0] m_chan_q;
	logic [SMP_W-1:0] m_filt_q;

	logic            acc;
	logic [CH_W-1:0] ch_in;
	logic            ch_ok;
	addr_t           base;
	wr_req_t         wr;
	rd_req_t         rd;
	smp_t            rd_data;
	logic            scan_done;
	sum_t            trim;
	logic            div_done;
	smp_t            quot;
	logic            out_free;
	logic            out_load;
	smp_t            out_val;

	assign acc      = s_tvalid && s_tready;
	assign ch_in    = s_tuser;
	assign ch_ok    = int'(ch_in) < CHANNELS;
	assign base     = ADDR_W'(int'(ch_in) * WINDOW);
	assign wr.en    = acc && ch_ok;
	assign wr.addr  = base + ADDR_W'(pos_q);
	assign wr.data  = SAMPLE_BITS'(s_tdata[SMP_W-1:0]);
	assign out_free = !m_valid_q || m_tready;
	assign out_load = out_free && (((state_q == ST_BUSY) && div_done) || (state_q == ST_HOLD));
	assign out_val  = (state_q == ST_HOLD) ? res_q : quot;

	tmf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	tmf_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wr.en),
		.base    (base),
		.rd      (rd),
		.rd_data (rd_data),
		.done    (scan_done),
		.trim    (trim)
	);

	tmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_done),
		.trim   (trim),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (wr.en && (ch_in == CH_W'(CHANNELS - 1))) begin
				pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ch_ok ? ST_BUSY : ST_HOLD;
					end
				end
				ST_BUSY: begin
					if (div_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_q <= ch_in;
		end
		if (acc && !ch_ok) begin
			res_q <= '0;
		end else if ((state_q == ST_BUSY) && div_done && !out_free) begin
			res_q <= quot;
		end
		if (out_load) begin
			m_chan_q <= ch_q;
			m_filt_q <= SMP_W'(out_val);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_chan_q;
	assign m_tdata  = TDATA_W'(m_filt_q);

	`ASSERT_PROP(a_pos_range, clk, arst_n, int'(pos_q) < WINDOW)
	`ASSERT_PROP(a_accept_blocks, clk, arst_n, acc |=> !s_tready)
	`ASSERT_PROP(a_done_in_busy, clk, arst_n, div_done |-> (state_q == ST_BUSY))
endmodule
